>>> rtl/core/lfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfc_pkg
// Shared types, codes and the byte-wide CRC-16 (ISO 13239, reflected) update
// for the link frame checker.
// ----------------------------------------------------------------------------
package lfc_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 6;
    localparam int PLEN_W   = 5;
    localparam int STATUS_W = 2;
    localparam int CRC_W    = 16;

    // frame status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_LEN = 2'd2;

    // configuration register indexes
    localparam logic CFG_ALT_CRC_INIT = 1'b0;
    localparam logic CFG_FINAL_INVERT = 1'b1;

    localparam logic [CRC_W-1:0] CRC_INIT_STD = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_INIT_ALT = 16'h6363;
    localparam logic [CRC_W-1:0] CRC_ONES     = 16'hFFFF;

    localparam logic [PLEN_W-1:0] PLEN_MAX = 5'd31;

    typedef struct packed {
        logic                is_status;
        logic [BYTE_W-1:0]   payload_byte;
        logic [STATUS_W-1:0] frame_status;
        logic [PLEN_W-1:0]   payload_length;
    } result_t;

    // One byte through the reflected CRC-16 (x^16 + x^12 + x^5 + 1)
    function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] t0;
        logic [BYTE_W-1:0] t;
        t0 = b ^ crc[7:0];
        t  = t0 ^ {t0[3:0], 4'h0};
        crc16_update = {8'h00, crc[15:8]}
                     ^ {t, 8'h00}
                     ^ {5'b00000, t, 3'b000}
                     ^ {12'h000, t[7:4]};
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/llc_frame_check_with_crc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted byte's result reaches the m_ channel in the cycle after it is
// accepted. One byte per cycle while s_ready is high; the CRC byte update and
// the countdown run in a single pass between the input port and the result
// register. The low CRC byte and accepted length bytes produce no result
// transaction. Reset (aresetn, synchronous, active low) clears frame state
// and the result valid; alt_crc_init resets to 0 and final_invert to 1.
// ----------------------------------------------------------------------------
// llc_frame_check_with_crc_core
// Receive-side link frame checker: length byte, payload pass-through and a
// CRC-16 (ISO 13239) check giving one status transaction per frame.
// ----------------------------------------------------------------------------
module llc_frame_check_with_crc_core
    import lfc_pkg::*;
#(
    parameter int MAX_FRAME_LENGTH = 33
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_addr,
    input  wire logic                cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [BYTE_W-1:0]   s_rx_byte,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_is_status,
    output logic [BYTE_W-1:0]        m_payload_byte,
    output logic [STATUS_W-1:0]      m_frame_status,
    output logic [PLEN_W-1:0]        m_payload_length
);

    logic    alt_crc_init_reg;
    logic    final_invert_reg;
    logic    accept;
    logic    res_valid;
    result_t res;
    result_t m_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alt_crc_init_reg <= 1'b0;
            final_invert_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ALT_CRC_INIT: alt_crc_init_reg <= cfg_wdata;
                CFG_FINAL_INVERT: final_invert_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    assign accept = s_valid && s_ready;

    lfc_frame_ctrl #(
        .MAX_FRAME_LENGTH(MAX_FRAME_LENGTH)
    ) u_frame_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (accept),
        .rx_byte      (s_rx_byte),
        .alt_crc_init (alt_crc_init_reg),
        .final_invert (final_invert_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    lfc_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .res_valid  (res_valid),
        .res        (res),
        .load_ready (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (m_res)
    );

    assign m_is_status      = m_res.is_status;
    assign m_payload_byte   = m_res.payload_byte;
    assign m_frame_status   = m_res.frame_status;
    assign m_payload_length = m_res.payload_length;

`ifndef ASSERT_OFF
    a_status_no_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_status) |-> (m_payload_byte == '0))
        else $error("status transaction carries a payload byte");

    a_payload_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_status) |-> (m_frame_status == STATUS_OK && m_payload_length == '0))
        else $error("payload transaction carries status fields");

    a_bad_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_status == STATUS_BAD_LEN) |-> (m_payload_length == '0))
        else $error("bad-length status reports a payload length");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty result register");
`endif

endmodule
`default_nettype wire

>>> rtl/core/lfc_frame_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfc_frame_ctrl
// Frame parser: length check, running CRC, byte countdown and the result
// item, if any, for each accepted byte.
// ----------------------------------------------------------------------------
module lfc_frame_ctrl
    import lfc_pkg::*;
#(
    parameter int MAX_FRAME_LENGTH = 33
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic              alt_crc_init,
    input  wire logic              final_invert,
    output logic                   res_valid,
    output result_t                res
);

    logic              in_frame_reg,     in_frame_next;
    logic [LEN_W-1:0]  bytes_left_reg,   bytes_left_next;
    logic [LEN_W-1:0]  frame_length_reg, frame_length_next;
    logic [CRC_W-1:0]  crc_reg,          crc_next;
    logic [BYTE_W-1:0] crc_low_reg,      crc_low_next;

    logic              len_bad;
    logic [CRC_W-1:0]  crc_init;
    logic [CRC_W-1:0]  crc_final;
    logic [LEN_W-1:0]  plen_full;
    logic [PLEN_W-1:0] plen;
    logic              crc_ok;

    assign len_bad   = (rx_byte < 8'd2) || (rx_byte > BYTE_W'(MAX_FRAME_LENGTH));
    assign crc_init  = alt_crc_init ? CRC_INIT_ALT : CRC_INIT_STD;
    assign crc_final = final_invert ? (crc_reg ^ CRC_ONES) : crc_reg;
    assign crc_ok    = (crc_final[7:0] == crc_low_reg) && (crc_final[15:8] == rx_byte);
    assign plen_full = frame_length_reg - LEN_W'(2);
    assign plen      = (plen_full > LEN_W'(PLEN_MAX)) ? PLEN_MAX : plen_full[PLEN_W-1:0];

    always_comb begin
        in_frame_next     = in_frame_reg;
        bytes_left_next   = bytes_left_reg;
        frame_length_next = frame_length_reg;
        crc_next          = crc_reg;
        crc_low_next      = crc_low_reg;
        res_valid         = 1'b0;
        res               = '0;
        if (!in_frame_reg) begin
            if (len_bad) begin
                // reject and stay hunting for a length byte
                res_valid          = 1'b1;
                res.is_status      = 1'b1;
                res.frame_status   = STATUS_BAD_LEN;
            end else begin
                in_frame_next     = 1'b1;
                frame_length_next = rx_byte[LEN_W-1:0];
                bytes_left_next   = rx_byte[LEN_W-1:0];
                crc_next          = crc16_update(crc_init, rx_byte);
            end
        end else if (bytes_left_reg > LEN_W'(2)) begin
            crc_next         = crc16_update(crc_reg, rx_byte);
            bytes_left_next  = bytes_left_reg - LEN_W'(1);
            res_valid        = 1'b1;
            res.payload_byte = rx_byte;
        end else if (bytes_left_reg == LEN_W'(2)) begin
            // hold the low CRC byte until the high one arrives
            crc_low_next    = rx_byte;
            bytes_left_next = LEN_W'(1);
        end else begin
            in_frame_next      = 1'b0;
            bytes_left_next    = '0;
            res_valid          = 1'b1;
            res.is_status      = 1'b1;
            res.frame_status   = crc_ok ? STATUS_OK : STATUS_CRC_ERR;
            res.payload_length = plen;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg     <= 1'b0;
            bytes_left_reg   <= '0;
            frame_length_reg <= '0;
            crc_reg          <= '0;
            crc_low_reg      <= '0;
        end else if (advance) begin
            in_frame_reg     <= in_frame_next;
            bytes_left_reg   <= bytes_left_next;
            frame_length_reg <= frame_length_next;
            crc_reg          <= crc_next;
            crc_low_reg      <= crc_low_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/lfc_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfc_out_reg
// Result register with valid/ready handshake; takes a new result whenever
// the held one is empty or leaving.
// ----------------------------------------------------------------------------
module lfc_out_reg
    import lfc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire logic    res_valid,
    input  wire result_t res,
    output logic         load_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_res
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign load_ready = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign m_res      = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = res_valid;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res_valid) begin
            data_reg <= res;
        end
    end

endmodule
`default_nettype wire
